@@ src/skf_pkg.sv @@
// ----------------------------------------------------------------------------
// skf_pkg: shared types and constants of the scalar Kalman filter
// Fixed-point widths, register indexes and reset values of the filter.
// ----------------------------------------------------------------------------
package skf_pkg;

    localparam int VAL_W    = 32;   // signed Q16.16 value
    localparam int UNC_W    = 24;   // unsigned Q8.16 noise / uncertainty
    localparam int SUM_W    = UNC_W + 1;
    localparam int GAIN_W   = 17;   // Q1.16 gain, 0 .. 1.0 inclusive
    localparam int MCAND_W  = VAL_W + 2;
    localparam int ACC_W    = MCAND_W + 1;
    localparam int PROD_W   = ACC_W + GAIN_W;
    localparam int FRAC_W   = 16;
    localparam int DELTA_W  = PROD_W - FRAC_W;
    localparam int STEPS    = GAIN_W;
    localparam int CNT_W    = $clog2(STEPS + 1);
    localparam int CFG_IDX_W = 8;

    typedef logic signed [VAL_W-1:0]   val_t;
    typedef logic        [UNC_W-1:0]   unc_t;
    typedef logic        [SUM_W-1:0]   sum_t;
    typedef logic        [GAIN_W-1:0]  gain_t;
    typedef logic signed [MCAND_W-1:0] mcand_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [DELTA_W-1:0] delta_t;
    typedef logic        [CNT_W-1:0]   cnt_t;
    typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_PROCESS_NOISE     = cfg_idx_t'(0);
    localparam cfg_idx_t REG_MEASUREMENT_NOISE = cfg_idx_t'(1);

    localparam unc_t  PROCESS_NOISE_RST     = unc_t'(655);
    localparam unc_t  MEASUREMENT_NOISE_RST = unc_t'(6554);
    localparam unc_t  UNCERTAINTY_RST       = unc_t'(655);
    localparam unc_t  UNC_MAX               = '1;
    localparam gain_t GAIN_ONE              = gain_t'(65536);
    localparam prod_t HALF_LSB              = prod_t'(32768);

endpackage

@@ src/skf_meas_if.sv @@
// ----------------------------------------------------------------------------
// skf_meas_if: measurement channel
// Valid/ready channel carrying one signed Q16.16 sensor sample per request.
// ----------------------------------------------------------------------------
interface skf_meas_if;
    logic          valid;
    logic          ready;
    skf_pkg::val_t measurement;

    modport source (output valid, output measurement, input ready);
    modport sink   (input valid, input measurement, output ready);
endinterface

@@ src/skf_result_if.sv @@
// ----------------------------------------------------------------------------
// skf_result_if: result channel
// Valid/ready channel carrying the updated estimate and its uncertainty.
// ----------------------------------------------------------------------------
interface skf_result_if;
    logic          valid;
    logic          ready;
    skf_pkg::val_t filtered_value;
    skf_pkg::unc_t estimate_uncertainty;

    modport source (output valid, output filtered_value, output estimate_uncertainty,
                    input ready);
    modport sink   (input valid, input filtered_value, input estimate_uncertainty,
                    output ready);
endinterface

@@ src/skf_cfg_if.sv @@
// ----------------------------------------------------------------------------
// skf_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface skf_cfg_if;
    logic              valid;
    logic              ready;
    skf_pkg::cfg_idx_t index;
    skf_pkg::unc_t     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/skf_div.sv @@
// ----------------------------------------------------------------------------
// skf_div: serial gain divider
// Restoring divider, one quotient bit per cycle: q = floor(num * 2^16 / den).
// Requires num <= den; a zero denominator yields zero.
// ----------------------------------------------------------------------------
module skf_div
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  skf_pkg::unc_t num,
    input  skf_pkg::sum_t den,
    output logic          done,
    output skf_pkg::gain_t quo
);
    import skf_pkg::*;

    logic [SUM_W:0]   rem_reg, rem_next;
    sum_t             den_reg;
    gain_t            quo_reg;
    logic             zero_reg;
    cnt_t             cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [SUM_W+1:0] trial;
    logic             q_bit;

    always_comb
    begin
        trial    = {1'b0, rem_reg} - {2'b00, den_reg};
        q_bit    = ~trial[SUM_W+1];
        rem_next = q_bit ? trial[SUM_W:0] : rem_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= cnt_t'(STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - cnt_t'(1);
                if (cnt_reg == cnt_t'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: shift the partial remainder left after each trial subtract
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= {2'b00, num};
            den_reg  <= den;
            quo_reg  <= '0;
            zero_reg <= (den == '0);
        end
        else if (busy_reg)
        begin
            rem_reg <= {rem_next[SUM_W-1:0], 1'b0};
            quo_reg <= {quo_reg[GAIN_W-2:0], q_bit};
        end
    end

    assign done = done_reg;
    assign quo  = zero_reg ? '0 : quo_reg;

endmodule

@@ src/skf_mul.sv @@
// ----------------------------------------------------------------------------
// skf_mul: serial shift-add multiplier
// Signed multiplicand times unsigned 17-bit factor, one factor bit per cycle.
// ----------------------------------------------------------------------------
module skf_mul
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  skf_pkg::mcand_t mcand,
    input  skf_pkg::gain_t  mult,
    output logic            done,
    output skf_pkg::prod_t  prod
);
    import skf_pkg::*;

    acc_t   hi_reg;
    gain_t  lo_reg;
    mcand_t mc_reg;
    cnt_t   cnt_reg;
    logic   busy_reg;
    logic   done_reg;
    acc_t   sum;

    assign sum = hi_reg + (lo_reg[0] ? acc_t'(mc_reg) : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= cnt_t'(STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - cnt_t'(1);
                if (cnt_reg == cnt_t'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // add on the low factor bit, then shift the accumulator right one place
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            hi_reg <= '0;
            lo_reg <= mult;
            mc_reg <= mcand;
        end
        else if (busy_reg)
        begin
            hi_reg <= {sum[ACC_W-1], sum[ACC_W-1:1]};
            lo_reg <= {sum[0], lo_reg[GAIN_W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = {hi_reg, lo_reg};

endmodule

@@ src/scalar_kalman_filter_top.sv @@
// ----------------------------------------------------------------------------
// scalar_kalman_filter_top: one-dimensional fixed-point Kalman filter
// Keeps an estimate and its uncertainty and updates both per measurement.
// ----------------------------------------------------------------------------
// Usage:
//   meas   : valid/ready sink, one signed Q16.16 sample per request.
//   result : valid/ready source, new estimate (Q16.16) and uncertainty
//            (Q8.16), exactly one result request per measurement.
//   cfg    : valid/ready write port; index 0 = process noise, index 1 =
//            measurement noise (Q8.16). Other indexes are dropped. Always
//            ready; write only while no measurement is in flight.
// Steps: from accepted measurement to result valid, the prediction state, the
//   serial gain division (one quotient bit a cycle), the two serial multiplies
//   (run side by side, one gain bit a cycle), the rounding state and the
//   update, plus setup handoffs.
// Flow: a new measurement is accepted only in the idle state, after the previous
//   one has been updated, so measurements do not overlap in the datapath.
// Reset: estimate 0, uncertainty 655 (0.01), process noise 655, measurement
//   noise 6554 (0.1); no result pending.
// Stall: a finished result waits in the output register while the next
//   measurement is accepted and computed; the update stage holds until the
//   register is free.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_top
(
    input  logic clk,
    input  logic rst_n,
    skf_meas_if.sink     meas,
    skf_result_if.source result,
    skf_cfg_if.sink      cfg
);
    import skf_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PRED  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_ROUND = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg, state_next;

    // configuration and filter state
    unc_t process_noise_reg;
    unc_t measurement_noise_reg;
    val_t estimate_reg;
    unc_t uncertainty_reg;

    // per-item working registers
    val_t   meas_reg;
    unc_t   pp_reg;
    mcand_t diff_reg;
    delta_t delta_reg;
    unc_t   np_reg;

    // output register
    logic out_valid_reg;
    val_t out_value_reg;
    unc_t out_unc_reg;

    // prediction
    sum_t   pp_sum;
    unc_t   pp_sat;
    sum_t   den;

    // serial units
    logic   div_done;
    gain_t  div_q;
    logic   mul_start;
    logic   mul_est_done;
    logic   mul_unc_done;
    prod_t  prod_est;
    prod_t  prod_unc;

    // rounding and update
    prod_t  round_est;
    prod_t  round_unc;
    logic [PROD_W-1:FRAC_W] np_wide;
    delta_t est_sum;
    val_t   est_clamped;

    logic   in_accept;
    logic   out_free;
    logic   update;

    assign in_accept = meas.valid & meas.ready;
    assign meas.ready = (state_reg == S_IDLE);
    assign out_free  = ~out_valid_reg | result.ready;
    assign update    = (state_reg == S_DONE) & out_free;
    assign cfg.ready = 1'b1;

    // predict: P' = sat(P + Q), D = P' + R
    always_comb
    begin
        pp_sum = {1'b0, uncertainty_reg} + {1'b0, process_noise_reg};
        pp_sat = pp_sum[UNC_W] ? UNC_MAX : pp_sum[UNC_W-1:0];
        den    = {1'b0, pp_sat} + {1'b0, measurement_noise_reg};
    end

    skf_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_PRED),
        .num   (pp_sat),
        .den   (den),
        .done  (div_done),
        .quo   (div_q)
    );

    // both multiplies start as soon as the gain is known
    assign mul_start = (state_reg == S_DIV) & div_done;

    skf_mul u_mul_est
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .mcand (diff_reg),
        .mult  (div_q),
        .done  (mul_est_done),
        .prod  (prod_est)
    );

    skf_mul u_mul_unc
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .mcand (mcand_t'({1'b0, pp_reg})),
        .mult  (GAIN_ONE - div_q),
        .done  (mul_unc_done),
        .prod  (prod_unc)
    );

    // round half up, then add and clamp to the signed value range
    always_comb
    begin
        round_est = prod_est + HALF_LSB;
        round_unc = prod_unc + HALF_LSB;
        np_wide   = round_unc[PROD_W-1:FRAC_W];
        est_sum   = delta_t'(estimate_reg) + delta_reg;
        if (est_sum > delta_t'(val_t'({1'b0, {(VAL_W-1){1'b1}}})))
            est_clamped = {1'b0, {(VAL_W-1){1'b1}}};
        else if (est_sum < delta_t'(val_t'({1'b1, {(VAL_W-1){1'b0}}})))
            est_clamped = {1'b1, {(VAL_W-1){1'b0}}};
        else
            est_clamped = est_sum[VAL_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_accept) state_next = S_PRED;
            S_PRED:  state_next = S_DIV;
            S_DIV:   if (div_done) state_next = S_MUL;
            S_MUL:   if (mul_est_done & mul_unc_done) state_next = S_ROUND;
            S_ROUND: state_next = S_DONE;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= S_IDLE;
            process_noise_reg     <= PROCESS_NOISE_RST;
            measurement_noise_reg <= MEASUREMENT_NOISE_RST;
            estimate_reg          <= '0;
            uncertainty_reg       <= UNCERTAINTY_RST;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_PROCESS_NOISE:     process_noise_reg     <= cfg.data;
                    REG_MEASUREMENT_NOISE: measurement_noise_reg <= cfg.data;
                    default: ;
                endcase
            end
            // advance filter state and load the result in one step
            if (update)
            begin
                estimate_reg    <= est_clamped;
                uncertainty_reg <= np_reg;
                out_valid_reg   <= 1'b1;
            end
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            meas_reg <= meas.measurement;
        if (state_reg == S_PRED)
        begin
            pp_reg   <= pp_sat;
            diff_reg <= mcand_t'(meas_reg) - mcand_t'(estimate_reg);
        end
        if (state_reg == S_ROUND)
        begin
            delta_reg <= round_est[PROD_W-1:FRAC_W];
            np_reg    <= (|np_wide[PROD_W-1:FRAC_W+UNC_W]) ? UNC_MAX
                                                           : np_wide[FRAC_W+UNC_W-1:FRAC_W];
        end
        if (update)
        begin
            out_value_reg <= est_clamped;
            out_unc_reg   <= np_reg;
        end
    end

    assign result.valid                = out_valid_reg;
    assign result.filtered_value       = out_value_reg;
    assign result.estimate_uncertainty = out_unc_reg;

endmodule

@@ sim/scalar_kalman_filter_top_tb.sv @@
// ----------------------------------------------------------------------------
// scalar_kalman_filter_top_tb: self-checking bench of the scalar Kalman filter
// Drives measurements and register writes through the valid/ready channels,
// mirrors the filter state in a scoreboard and checks every result in order.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_top_tb;

    import skf_pkg::*;

    // Accept-to-result latency of the block, plus some slack for idle waits.
    localparam int LATENCY      = 39;
    localparam int SETTLE_WAIT  = LATENCY + 8;
    localparam int LIMIT_CYCLES = 600000;
    localparam int NUM_SEGS     = 8;
    localparam int SEG_ITEMS    = 216;

    typedef struct packed {
        val_t value;
        unc_t unc;
    } filter_out_t;

    // ------------------------------------------------------------------------
    // Scoreboard: mirror of the filter state and the queue of expected results
    // ------------------------------------------------------------------------
    class kalman_scoreboard;
        unc_t        proc_noise;
        unc_t        meas_noise;
        val_t        est_q;
        unc_t        unc_q;
        filter_out_t expected_q[$];
        int unsigned errors;

        function new();
            proc_noise = PROCESS_NOISE_RST;
            meas_noise = MEASUREMENT_NOISE_RST;
            est_q      = '0;
            unc_q      = UNCERTAINTY_RST;
            errors     = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, unc_t data);
            if (idx == REG_PROCESS_NOISE)
                proc_noise = data;
            else if (idx == REG_MEASUREMENT_NOISE)
                meas_noise = data;
        endfunction

        // Advance the filter by one accepted measurement and queue the result.
        function void note_measurement(val_t m);
            longint pp;
            longint den;
            longint gain;
            longint diff;
            longint delta;
            longint ne;
            longint np;
            pp = longint'(unc_q) + longint'(proc_noise);
            if (pp > 64'sh0000_0000_00FF_FFFF)
                pp = 64'sh0000_0000_00FF_FFFF;
            den  = pp + longint'(meas_noise);
            gain = (den == 0) ? 0 : (pp << 16) / den;
            diff  = longint'(m) - longint'(est_q);
            delta = (diff * gain + 32768) >>> 16;
            ne    = longint'(est_q) + delta;
            if (ne > 64'sd2147483647)
                ne = 64'sd2147483647;
            if (ne < -64'sd2147483648)
                ne = -64'sd2147483648;
            np = ((65536 - gain) * pp + 32768) >>> 16;
            if (np > 64'sh0000_0000_00FF_FFFF)
                np = 64'sh0000_0000_00FF_FFFF;
            est_q = val_t'(ne);
            unc_q = unc_t'(np);
            expected_q.push_back('{value: est_q, unc: unc_q});
        endfunction

        function void check_result(val_t value, unc_t unc);
            filter_out_t exp_out;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h / %h",
                         $time, value, unc);
                errors++;
                return;
            end
            exp_out = expected_q.pop_front();
            if (value !== exp_out.value)
            begin
                $display("%0t: filtered_value mismatch, expected %h, actual %h",
                         $time, exp_out.value, value);
                errors++;
            end
            if (unc !== exp_out.unc)
            begin
                $display("%0t: estimate_uncertainty mismatch, expected %h, actual %h",
                         $time, exp_out.unc, unc);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, channels and the block
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    skf_meas_if   meas_ch ();
    skf_result_if res_ch ();
    skf_cfg_if    cfg_ch ();

    scalar_kalman_filter_top uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .meas   (meas_ch.sink),
        .result (res_ch.source),
        .cfg    (cfg_ch.sink)
    );

    kalman_scoreboard sb = new();

    int          tx_idle_pct;     // chance in a hundred that the sender idles a cycle
    int          rx_stall_pct;    // chance in a hundred that the receiver stalls a cycle
    int unsigned cycle_count;

    // ------------------------------------------------------------------------
    // Monitors: sample every handshake at the rising edge, before the drivers'
    // nonblocking updates land, and feed the scoreboard.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && meas_ch.valid && meas_ch.ready)
            sb.note_measurement(meas_ch.measurement);
        if (rst_n && res_ch.valid && res_ch.ready)
            sb.check_result(res_ch.filtered_value, res_ch.estimate_uncertainty);
        if (rst_n && cfg_ch.valid && cfg_ch.ready)
            sb.write_reg(cfg_ch.index, cfg_ch.data);
    end

    // Receiver: stall at random with the current phase's rate; one update per edge.
    always @(posedge clk)
        res_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);

    // Watchdog: give up if the run hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("%0t: timeout after %0d cycles, %0d results still pending",
                     $time, cycle_count, sb.pending());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------

    // Send one measurement request. Leave valid high after the handshake so that
    // back-to-back requests never lower and raise valid in the same step; a gap
    // drops valid first and holds it low for the drawn gap.
    task automatic send_meas(input val_t m);
        int unsigned gap;
        gap = 0;
        while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct)
            gap++;
        if (gap != 0)
        begin
            meas_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        meas_ch.valid       <= 1'b1;
        meas_ch.measurement <= m;
        do
            @(posedge clk);
        while (!meas_ch.ready);
    endtask

    // Drop the request, wait until every expected result has come, then let the
    // pipeline run out before anything touches the registers.
    task automatic settle();
        meas_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    // Write one register; hold valid until the port takes it, then drop it.
    task automatic write_reg(input cfg_idx_t idx, input unc_t data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_noise(input unc_t pn, input unc_t mn);
        settle();
        write_reg(REG_PROCESS_NOISE, pn);
        write_reg(REG_MEASUREMENT_NOISE, mn);
    endtask

    // Mix full-range samples with ones near the current estimate and near zero, so the
    // filter tracks a signal part of the time and still sees wild jumps and extremes.
    function automatic val_t pick_measurement();
        int off;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return val_t'($urandom());
            4, 5, 6:
            begin
                off = int'($urandom_range(0, 20'hFFFFF)) - 20'h80000;
                return sb.est_q + val_t'(off);
            end
            7:       return $urandom_range(0, 1) ? val_t'(32'h7FFF_FFFF) : val_t'(32'h8000_0000);
            8:       return val_t'(int'($urandom_range(0, 2)) - 1);
            default: return sb.est_q;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        unc_t pn;
        unc_t mn;

        rst_n               = 1'b0;
        meas_ch.valid       = 1'b0;
        meas_ch.measurement = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = REG_PROCESS_NOISE;
        cfg_ch.data         = '0;
        res_ch.ready        = 1'b0;
        tx_idle_pct         = 0;
        rx_stall_pct        = 0;
        cycle_count         = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: value extremes and small values with the reset noise settings.
        send_meas(val_t'(32'h7FFF_FFFF));
        send_meas(val_t'(32'h8000_0000));
        send_meas(val_t'(32'h0000_0000));
        send_meas(val_t'(32'hFFFF_FFFF));
        send_meas(val_t'(32'h0000_0001));
        send_meas(val_t'(32'h0001_0000));

        // Unknown register indexes must be dropped.
        settle();
        write_reg(cfg_idx_t'(2), '1);
        write_reg('1, '0);
        send_meas(val_t'(32'h1234_5678));

        // Zero measurement noise: gain of exactly one, full swing across the range.
        set_noise(PROCESS_NOISE_RST, '0);
        send_meas(val_t'(32'h7FFF_FFFF));
        send_meas(val_t'(32'h8000_0000));

        // Both noises zero with the uncertainty now at zero: zero denominator.
        set_noise('0, '0);
        send_meas(val_t'(32'h5555_5555));
        send_meas(val_t'(32'hAAAA_AAAA));

        // Largest noises: the predicted uncertainty saturates.
        set_noise(UNC_MAX, UNC_MAX);
        send_meas(val_t'(32'h7FFF_FFFF));
        send_meas(val_t'(32'h8000_0000));
        send_meas(val_t'(32'h0000_0000));

        set_noise(UNC_MAX, '0);
        send_meas(val_t'(32'h8000_0000));
        send_meas(val_t'(32'h7FFF_FFFF));

        set_noise('0, UNC_MAX);
        send_meas(val_t'(32'h8000_0000));
        send_meas(val_t'(32'h7FFF_FFFF));

        // Random segments: each picks a noise setting and an idling pattern;
        // every pattern is used twice across the run.
        for (int seg = 0; seg < NUM_SEGS; seg++)
        begin
            case (seg)
                0:       begin pn = PROCESS_NOISE_RST;           mn = MEASUREMENT_NOISE_RST; end
                1:       begin pn = '0;                          mn = '0; end
                2:       begin pn = UNC_MAX;                     mn = UNC_MAX; end
                3:       begin pn = '0;                          mn = UNC_MAX; end
                4:       begin pn = UNC_MAX;                     mn = '0; end
                5:       begin pn = unc_t'($urandom());          mn = unc_t'($urandom()); end
                6:       begin pn = unc_t'($urandom_range(0, 4095));
                               mn = unc_t'($urandom_range(0, 4095)); end
                default: begin pn = unc_t'($urandom_range(0, 65535));
                               mn = unc_t'($urandom()); end
            endcase
            set_noise(pn, mn);
            write_reg(cfg_idx_t'($urandom_range(2, 255)), unc_t'($urandom()));

            case (seg % 4)
                0:       begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
                1:       begin tx_idle_pct = 56; rx_stall_pct <= 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct <= 56; end
                default: begin tx_idle_pct = 29; rx_stall_pct <= 29; end
            endcase

            for (int i = 0; i < SEG_ITEMS; i++)
            begin
                // Hold the sender mid-segment until the pipeline has drained.
                if (i == SEG_ITEMS / 2)
                    settle();
                send_meas(pick_measurement());
            end
        end

        // Drain: wait for every result, then watch for strays a while longer.
        meas_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ scalar_kalman_filter_top.f @@
src/skf_pkg.sv
src/skf_meas_if.sv
src/skf_result_if.sv
src/skf_cfg_if.sv
src/skf_div.sv
src/skf_mul.sv
src/scalar_kalman_filter_top.sv
sim/scalar_kalman_filter_top_tb.sv
